// ===== src/gtmd_pkg.sv =====
`default_nettype none

package gtmd_pkg;

  // Sequencer states, one-hot
  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_SQ_M    = 20'h00002,
    ST_SQ_A    = 20'h00004,
    ST_FLT_M   = 20'h00008,
    ST_FLT_A   = 20'h00010,
    ST_LIN_M   = 20'h00020,
    ST_LIN_A   = 20'h00040,
    ST_UPCHK   = 20'h00080,
    ST_DIV     = 20'h00100,
    ST_SQRT    = 20'h00200,
    ST_SQ_DONE = 20'h00400,
    ST_IDX_M   = 20'h00800,
    ST_IDX_A   = 20'h01000,
    ST_K_M     = 20'h02000,
    ST_K_A     = 20'h04000,
    ST_CORD    = 20'h08000,
    ST_TILT    = 20'h10000,
    ST_MOT_M   = 20'h20000,
    ST_MOT_A   = 20'h40000,
    ST_DONE    = 20'h80000
  } state_e;

  // Consumer of the square-root result
  typedef enum logic [1:0] {
    JOB_UP   = 2'd0,
    JOB_ACOS = 2'd1,
    JOB_LIN  = 2'd2,
    JOB_GYR  = 2'd3
  } sq_job_e;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd4;

  localparam logic [15:0] RST_FILTER_WEIGHT    = 16'd19661;
  localparam logic [15:0] RST_GATE_LOW         = 16'd1638;
  localparam logic [15:0] RST_GATE_HIGH        = 16'd2458;
  localparam logic [7:0]  RST_GYRO_WEIGHT      = 8'd10;
  localparam logic [31:0] RST_MOTION_THRESHOLD = 32'd2048;

  localparam int CORDIC_STEPS = 18;
  localparam int DIV_STEPS    = 28;
  localparam int SQRT_STEPS   = 30;

  // atan(2^-i) in 1/64 degree, Q16
  localparam logic signed [31:0] ATAN_Q16 [CORDIC_STEPS] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833
  };

  localparam logic signed [31:0] TILT_MAX_Q16 = 32'sd377487360;
  localparam logic [36:0]        SMALL_G_LIM  = 37'd1048576;
  localparam logic signed [15:0] UP_ONE       = 16'sd16384;

endpackage

`default_nettype wire

// ===== src/gravity_tilt_motion_detector_top.sv =====
`default_nettype none
// Gravity tilt and motion detector.
// Input channel (in_valid_i / in_stall_o): one accel + gyro sample per transfer.
// Output channel (out_valid_o / out_stall_i): one result per sample: gravity
// estimate, linear accel, normalised up vector, tilt and motion level.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; ready
// is always high, indexes beyond four are dropped.
// One sample is worked at a time by a sequencer around one shared multiplier,
// a restoring divider and a square-root unit that each produce one result bit
// (one root bit) per cycle, plus an 18 step CORDIC for the arccosine.
// The three 28 step divisions and six 30 step square roots dominate the work;
// when the up vector falls back to default, the divisions and three of the
// square roots are skipped, and a filter update adds its own multiply steps.
// The next sample is taken once the result sits in the output register, so
// a new sample is not accepted while the previous one is being worked.
// Reset loads the register defaults, clears the gravity estimate and marks the
// next sample as the first. While the receiver stalls, the result is held in
// the output register and work continues up to the final load, which waits.

module gravity_tilt_motion_detector_top #(
  parameter int ACOS_TABLE_DEPTH = 1024
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [15:0]                   accel_x_i,
  input  wire  signed [15:0]                   accel_y_i,
  input  wire  signed [15:0]                   accel_z_i,
  input  wire  signed [15:0]                   rate_x_i,
  input  wire  signed [15:0]                   rate_y_i,
  input  wire  signed [15:0]                   rate_z_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [15:0]                   grav_x_o,
  output logic signed [15:0]                   grav_y_o,
  output logic signed [15:0]                   grav_z_o,
  output logic signed [16:0]                   lin_x_o,
  output logic signed [16:0]                   lin_y_o,
  output logic signed [16:0]                   lin_z_o,
  output logic signed [15:0]                   up_x_o,
  output logic signed [15:0]                   up_y_o,
  output logic signed [15:0]                   up_z_o,
  output logic [12:0]                          tilt_o,
  output logic [31:0]                          motion_level_o,
  output logic                                 moving_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [gtmd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [31:0]                          cfg_data_i
);
  import gtmd_pkg::*;

  // Arccosine index range follows the table depth
  localparam int          KW  = $clog2(ACOS_TABLE_DEPTH);
  localparam int          DM1 = ACOS_TABLE_DEPTH - 1;
  localparam logic [27:0] NSQ = 28'(DM1 * DM1);

  // Configuration registers
  logic [15:0] cfg_w_q, cfg_gl_q, cfg_gh_q;
  logic [7:0]  cfg_gw_q;
  logic [31:0] cfg_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= RST_FILTER_WEIGHT;
      cfg_gl_q  <= RST_GATE_LOW;
      cfg_gh_q  <= RST_GATE_HIGH;
      cfg_gw_q  <= RST_GYRO_WEIGHT;
      cfg_thr_q <= RST_MOTION_THRESHOLD;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_WEIGHT:    cfg_w_q   <= cfg_data_i[15:0];
        REG_GATE_LOW:         cfg_gl_q  <= cfg_data_i[15:0];
        REG_GATE_HIGH:        cfg_gh_q  <= cfg_data_i[15:0];
        REG_GYRO_WEIGHT:      cfg_gw_q  <= cfg_data_i[7:0];
        REG_MOTION_THRESHOLD: cfg_thr_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Control state
  state_e     state_q, state_d;
  logic [2:0] i_q, i_d;          // loop index over axes / square operands
  logic [4:0] cnt_q, cnt_d;      // step counter of the iterative units
  sq_job_e    job_q, job_d;
  logic       first_q, first_d;
  logic       ovalid_q, ovalid_d;

  // Sample and estimate
  logic signed [15:0] a_q [3];
  logic signed [15:0] a_d [3];
  logic signed [15:0] r_q [3];
  logic signed [15:0] r_d [3];
  logic signed [15:0] g_q [3];
  logic signed [15:0] g_d [3];
  logic signed [16:0] lin_q [3];
  logic signed [16:0] lin_d [3];
  logic signed [15:0] up_q [3];
  logic signed [15:0] up_d [3];
  logic [31:0]        gsq_q [3];
  logic [31:0]        gsq_d [3];

  // Sums of squares and gate bounds
  logic [31:0] sacc_q, sacc_d, srate_q, srate_d, sgrav_q, sgrav_d;
  logic [33:0] slin_q, slin_d;
  logic [31:0] lo2_q, lo2_d;

  // Shared multiplier
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_q;

  // Divider
  logic [31:0] rem_q, rem_d;
  logic [28:0] quo_q, quo_d;

  // Square-root unit
  logic [59:0] sq_in_q, sq_in_d;
  logic [29:0] sq_root_q, sq_root_d;
  logic [33:0] sq_rem_q, sq_rem_d;

  // CORDIC and results
  logic [KW-1:0]      k_q, k_d;
  logic signed [32:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0] cz_q, cz_d;
  logic [12:0]        tilt_q, tilt_d;
  logic [16:0]        lmag_q, lmag_d;
  logic [22:0]        gmag_q, gmag_d;
  logic [31:0]        mot_q, mot_d;

  // Output register
  logic signed [15:0] og_q [3];
  logic signed [15:0] og_d [3];
  logic signed [16:0] olin_q [3];
  logic signed [16:0] olin_d [3];
  logic signed [15:0] oup_q [3];
  logic signed [15:0] oup_d [3];
  logic [12:0]        otilt_q, otilt_d;
  logic [31:0]        omot_q, omot_d;
  logic               omov_q, omov_d;

  // Datapath terms shared by several states
  logic [1:0]         ax_c, ax_start;
  logic signed [16:0] diff_c;
  logic [31:0]        gsq_sel;
  logic               div_ge;
  logic [32:0]        div_r2;
  logic               div_take;
  logic [28:0]        quo_n;
  logic [33:0]        sq_rem_n, sq_trial;
  logic               sq_take;
  logic [29:0]        sq_root_n;
  logic signed [32:0] cx_s, cy_s;
  logic signed [31:0] atan_c;
  logic [36:0]        g25;
  logic [14:0]        uz;
  logic [28:0]        ixw;
  logic signed [49:0] flt_t;
  logic signed [31:0] tz, tr;
  logic [32:0]        msum;

  always_comb begin
    if (i_q < 3'd3) begin
      ax_c = i_q[1:0];
    end else if (i_q < 3'd6) begin
      ax_c = 2'(i_q - 3'd3);
    end else begin
      ax_c = 2'd0;
    end
    ax_start = (state_q == ST_UPCHK || ax_c == 2'd2) ? 2'd0 : 2'(ax_c + 2'd1);
    diff_c   = {a_q[ax_c][15], a_q[ax_c]} - {g_q[ax_c][15], g_q[ax_c]};
    gsq_sel  = gsq_q[ax_start];
    div_ge   = (gsq_sel >= sgrav_q);
    div_r2   = {rem_q, 1'b0};
    div_take = (div_r2 >= {1'b0, sgrav_q});
    quo_n    = {quo_q[27:0], div_take};
    sq_rem_n  = {sq_rem_q[31:0], sq_in_q[59:58]};
    sq_trial  = {2'b00, sq_root_q, 2'b01};
    sq_take   = (sq_rem_n >= sq_trial);
    sq_root_n = {sq_root_q[28:0], sq_take};
    cx_s   = cx_q >>> cnt_q;
    cy_s   = cy_q >>> cnt_q;
    atan_c = (cnt_q < 5'(CORDIC_STEPS)) ? ATAN_Q16[cnt_q] : 32'sd0;
    g25    = {1'b0, sgrav_q, 4'b0} + {2'b0, sgrav_q, 3'b0} + {5'b0, sgrav_q};
    uz     = up_q[2][15] ? 15'(-up_q[2]) : up_q[2][14:0];
    ixw    = prod_q[28:0] + 29'd8192;
    flt_t  = prod_q + 50'sd32768;
    if (cz_q < 32'sd0) begin
      tz = 32'sd0;
    end else if (cz_q > TILT_MAX_Q16) begin
      tz = TILT_MAX_Q16;
    end else begin
      tz = cz_q;
    end
    tr   = tz + 32'sd32768;
    msum = {16'b0, lmag_q} + prod_q[32:0];
  end

  // Multiplier operand select
  always_comb begin
    mul_a = 25'sd0;
    mul_b = 25'sd0;
    unique case (state_q)
      ST_SQ_M: begin
        case (i_q)
          3'd0, 3'd1, 3'd2: mul_a = 25'(a_q[ax_c]);
          3'd3, 3'd4, 3'd5: mul_a = 25'(r_q[ax_c]);
          3'd6:             mul_a = {9'b0, cfg_gl_q};
          default:          mul_a = {9'b0, cfg_gh_q};
        endcase
        mul_b = mul_a;
      end
      ST_FLT_M: begin
        mul_a = 25'(diff_c);
        mul_b = {9'b0, cfg_w_q};
      end
      ST_LIN_M: begin
        mul_a = (i_q < 3'd3) ? 25'(diff_c) : 25'(g_q[ax_c]);
        mul_b = mul_a;
      end
      ST_IDX_M: begin
        mul_a = {10'b0, uz};
        mul_b = 25'(DM1);
      end
      ST_K_M: begin
        mul_a = {{(25-KW){1'b0}}, k_q};
        mul_b = mul_a;
      end
      ST_MOT_M: begin
        mul_a = {17'b0, cfg_gw_q};
        mul_b = {2'b0, gmag_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    job_d     = job_q;
    first_d   = first_q;
    ovalid_d  = ovalid_q;
    a_d       = a_q;
    r_d       = r_q;
    g_d       = g_q;
    lin_d     = lin_q;
    up_d      = up_q;
    gsq_d     = gsq_q;
    sacc_d    = sacc_q;
    srate_d   = srate_q;
    sgrav_d   = sgrav_q;
    slin_d    = slin_q;
    lo2_d     = lo2_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    sq_in_d   = sq_in_q;
    sq_root_d = sq_root_q;
    sq_rem_d  = sq_rem_q;
    k_d       = k_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    cz_d      = cz_q;
    tilt_d    = tilt_q;
    lmag_d    = lmag_q;
    gmag_d    = gmag_q;
    mot_d     = mot_q;
    og_d      = og_q;
    olin_d    = olin_q;
    oup_d     = oup_q;
    otilt_d   = otilt_q;
    omot_d    = omot_q;
    omov_d    = omov_q;

    // drop the result once it is taken
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          a_d     = '{accel_x_i, accel_y_i, accel_z_i};
          r_d     = '{rate_x_i, rate_y_i, rate_z_i};
          sacc_d  = '0;
          srate_d = '0;
          sgrav_d = '0;
          slin_d  = '0;
          i_d     = 3'd0;
          state_d = ST_SQ_M;
        end
      end
      ST_SQ_M: state_d = ST_SQ_A;
      ST_SQ_A: begin
        case (i_q)
          3'd0, 3'd1, 3'd2: sacc_d  = sacc_q + prod_q[31:0];
          3'd3, 3'd4, 3'd5: srate_d = srate_q + prod_q[31:0];
          3'd6:             lo2_d   = prod_q[31:0];
          default: ;
        endcase
        if (i_q == 3'd7) begin
          i_d = 3'd0;
          if (first_q) begin
            g_d     = a_q;
            first_d = 1'b0;
            state_d = ST_LIN_M;
          end else if (sacc_q > lo2_q && sacc_q < prod_q[31:0]) begin
            state_d = ST_FLT_M;
          end else begin
            state_d = ST_LIN_M;
          end
        end else begin
          i_d     = i_q + 3'd1;
          state_d = ST_SQ_M;
        end
      end
      ST_FLT_M: state_d = ST_FLT_A;
      ST_FLT_A: begin
        g_d[ax_c] = g_q[ax_c] + $signed(flt_t[31:16]);
        if (i_q == 3'd2) begin
          i_d     = 3'd0;
          state_d = ST_LIN_M;
        end else begin
          i_d     = i_q + 3'd1;
          state_d = ST_FLT_M;
        end
      end
      ST_LIN_M: begin
        if (i_q < 3'd3) begin
          lin_d[ax_c] = diff_c;
        end
        state_d = ST_LIN_A;
      end
      ST_LIN_A: begin
        if (i_q < 3'd3) begin
          slin_d = slin_q + prod_q[33:0];
        end else begin
          sgrav_d     = sgrav_q + prod_q[31:0];
          gsq_d[ax_c] = prod_q[31:0];
        end
        if (i_q == 3'd5) begin
          i_d     = 3'd0;
          state_d = ST_UPCHK;
        end else begin
          i_d     = i_q + 3'd1;
          state_d = ST_LIN_M;
        end
      end
      ST_UPCHK: begin
        if (g25 > SMALL_G_LIM) begin
          rem_d   = div_ge ? gsq_sel - sgrav_q : gsq_sel;
          quo_d   = {28'b0, div_ge};
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          up_d    = '{16'sd0, 16'sd0, UP_ONE};
          state_d = ST_IDX_M;
        end
      end
      ST_DIV: begin
        rem_d = div_take ? 32'(div_r2 - {1'b0, sgrav_q}) : div_r2[31:0];
        quo_d = quo_n;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          sq_in_d   = {31'b0, quo_n};
          sq_root_d = '0;
          sq_rem_d  = '0;
          cnt_d     = '0;
          job_d     = JOB_UP;
          state_d   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_rem_d  = sq_take ? sq_rem_n - sq_trial : sq_rem_n;
        sq_root_d = sq_root_n;
        sq_in_d   = {sq_in_q[57:0], 2'b00};
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          state_d = ST_SQ_DONE;
        end
      end
      ST_SQ_DONE: begin
        unique case (job_q)
          JOB_UP: begin
            up_d[ax_c] = g_q[ax_c][15] ? 16'sd0 - $signed(sq_root_q[15:0])
                                       : $signed(sq_root_q[15:0]);
            if (i_q == 3'd2) begin
              i_d     = 3'd0;
              state_d = ST_IDX_M;
            end else begin
              i_d     = i_q + 3'd1;
              rem_d   = div_ge ? gsq_sel - sgrav_q : gsq_sel;
              quo_d   = {28'b0, div_ge};
              cnt_d   = '0;
              state_d = ST_DIV;
            end
          end
          JOB_ACOS: begin
            cx_d    = $signed({3'b0, 15'(k_q), 15'b0});
            cy_d    = $signed({3'b0, sq_root_q});
            cz_d    = 32'sd0;
            cnt_d   = '0;
            state_d = ST_CORD;
          end
          JOB_LIN: begin
            lmag_d    = sq_root_q[16:0];
            sq_in_d   = {14'b0, srate_q, 14'b0};
            sq_root_d = '0;
            sq_rem_d  = '0;
            cnt_d     = '0;
            job_d     = JOB_GYR;
            state_d   = ST_SQRT;
          end
          default: begin
            gmag_d  = sq_root_q[22:0];
            state_d = ST_MOT_M;
          end
        endcase
      end
      ST_IDX_M: state_d = ST_IDX_A;
      ST_IDX_A: begin
        if (ixw[28:14] > 15'(DM1)) begin
          k_d = KW'(DM1);
        end else begin
          k_d = ixw[KW+13:14];
        end
        state_d = ST_K_M;
      end
      ST_K_M: state_d = ST_K_A;
      ST_K_A: begin
        sq_in_d   = {2'b00, NSQ - prod_q[27:0], 30'b0};
        sq_root_d = '0;
        sq_rem_d  = '0;
        cnt_d     = '0;
        job_d     = JOB_ACOS;
        state_d   = ST_SQRT;
      end
      ST_CORD: begin
        if (cy_q > 33'sd0) begin
          cx_d = cx_q + cy_s;
          cy_d = cy_q - cx_s;
          cz_d = cz_q + atan_c;
        end else begin
          cx_d = cx_q - cy_s;
          cy_d = cy_q + cx_s;
          cz_d = cz_q - atan_c;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = ST_TILT;
        end
      end
      ST_TILT: begin
        tilt_d    = tr[28:16];
        sq_in_d   = {26'b0, slin_q};
        sq_root_d = '0;
        sq_rem_d  = '0;
        cnt_d     = '0;
        job_d     = JOB_LIN;
        state_d   = ST_SQRT;
      end
      ST_MOT_M: state_d = ST_MOT_A;
      ST_MOT_A: begin
        mot_d   = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!ovalid_q || !out_stall_i) begin
          og_d     = g_q;
          olin_d   = lin_q;
          oup_d    = up_q;
          otilt_d  = tilt_q;
          omot_d   = mot_q;
          omov_d   = (mot_q > cfg_thr_q);
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      cnt_q    <= '0;
      job_q    <= JOB_UP;
      first_q  <= 1'b1;
      ovalid_q <= 1'b0;
      g_q      <= '{16'sd0, 16'sd0, 16'sd0};
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      cnt_q    <= cnt_d;
      job_q    <= job_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
      g_q      <= g_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    r_q       <= r_d;
    lin_q     <= lin_d;
    up_q      <= up_d;
    gsq_q     <= gsq_d;
    sacc_q    <= sacc_d;
    srate_q   <= srate_d;
    sgrav_q   <= sgrav_d;
    slin_q    <= slin_d;
    lo2_q     <= lo2_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    sq_in_q   <= sq_in_d;
    sq_root_q <= sq_root_d;
    sq_rem_q  <= sq_rem_d;
    k_q       <= k_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cz_q      <= cz_d;
    tilt_q    <= tilt_d;
    lmag_q    <= lmag_d;
    gmag_q    <= gmag_d;
    mot_q     <= mot_d;
    og_q      <= og_d;
    olin_q    <= olin_d;
    oup_q     <= oup_d;
    otilt_q   <= otilt_d;
    omot_q    <= omot_d;
    omov_q    <= omov_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign grav_x_o       = og_q[0];
  assign grav_y_o       = og_q[1];
  assign grav_z_o       = og_q[2];
  assign lin_x_o        = olin_q[0];
  assign lin_y_o        = olin_q[1];
  assign lin_z_o        = olin_q[2];
  assign up_x_o         = oup_q[0];
  assign up_y_o         = oup_q[1];
  assign up_z_o         = oup_q[2];
  assign tilt_o         = otilt_q;
  assign motion_level_o = omot_q;
  assign moving_o       = omov_q;

  // A transfer in starts the sequencer, which stalls the input next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < sgrav_q)
    else $error("divider remainder out of range");

  // Tilt never exceeds a right angle
  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tilt_o <= 13'd5760)
    else $error("tilt out of range");

endmodule

`default_nettype wire

// ===== bench/tb_gravity_tilt_motion_detector_top.sv =====
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] accel [3];
  logic signed [15:0] rate [3];
} imu_sample_t;

typedef struct {
  logic signed [15:0] grav [3];
  logic signed [16:0] lin [3];
  logic signed [15:0] up [3];
  logic [12:0]        tilt;
  logic [31:0]        motion_level;
  logic               moving;
} tilt_result_t;

class tilt_scoreboard;
  localparam int ACOS_DEPTH = 1024;

  logic [15:0]   filter_weight, gate_low, gate_high;
  logic [7:0]    gyro_weight;
  logic [31:0]   motion_threshold;
  longint        grav_est [3];
  bit            first_pending;
  logic [12:0]   acos_lut [ACOS_DEPTH];
  tilt_result_t  expected_q [$];
  int            errors, results_seen, samples_seen;
  int            gated_updates, default_up_count, moving_count;

  function new();
    int k;
    filter_weight    = gtmd_pkg::RST_FILTER_WEIGHT;
    gate_low         = gtmd_pkg::RST_GATE_LOW;
    gate_high        = gtmd_pkg::RST_GATE_HIGH;
    gyro_weight      = gtmd_pkg::RST_GYRO_WEIGHT;
    motion_threshold = gtmd_pkg::RST_MOTION_THRESHOLD;
    for (int i = 0; i < 3; i++) grav_est[i] = 0;
    first_pending = 1'b1;
    for (k = 0; k < ACOS_DEPTH; k++) acos_lut[k] = acos_entry(k, ACOS_DEPTH - 1);
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC on (k, sqrt(n^2 - k^2)), angle in 1/64 degree Q16
  static function logic [12:0] acos_entry(longint k, longint n);
    longint x, y, z, xs, ys;
    x = k * 32768;
    y = longint'(int_sqrt(64'(n * n - k * k) << 30));
    z = 0;
    for (int i = 0; i < gtmd_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(gtmd_pkg::ATAN_Q16[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(gtmd_pkg::ATAN_Q16[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(gtmd_pkg::TILT_MAX_Q16)) z = longint'(gtmd_pkg::TILT_MAX_Q16);
    return 13'((z + 32768) >>> 16);
  endfunction

  function void write_reg(logic [gtmd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      gtmd_pkg::REG_FILTER_WEIGHT:    filter_weight = data[15:0];
      gtmd_pkg::REG_GATE_LOW:         gate_low = data[15:0];
      gtmd_pkg::REG_GATE_HIGH:        gate_high = data[15:0];
      gtmd_pkg::REG_GYRO_WEIGHT:      gyro_weight = data[7:0];
      gtmd_pkg::REG_MOTION_THRESHOLD: motion_threshold = data;
      default: ;
    endcase
  endfunction

  function void note_sample(imu_sample_t s);
    tilt_result_t    r;
    longint          a [3], lin [3], t, g, q;
    longint unsigned s_acc, s_rate, s_lin, s_grav, uz, idx, lmag, gmag, motion;
    s_acc = 0; s_rate = 0; s_lin = 0; s_grav = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = s.accel[i];
      s_acc += 64'(a[i] * a[i]);
      s_rate += 64'(longint'(s.rate[i]) * longint'(s.rate[i]));
    end
    if (first_pending) begin
      for (int i = 0; i < 3; i++) grav_est[i] = a[i];
      first_pending = 1'b0;
    end else if (s_acc > 64'(gate_low) * 64'(gate_low) &&
                 s_acc < 64'(gate_high) * 64'(gate_high)) begin
      gated_updates++;
      for (int i = 0; i < 3; i++) begin
        t = (a[i] - grav_est[i]) * longint'({1'b0, filter_weight}) + 32768;
        grav_est[i] += t >>> 16;
      end
    end
    for (int i = 0; i < 3; i++) begin
      lin[i] = a[i] - grav_est[i];
      s_lin += 64'(lin[i] * lin[i]);
      s_grav += 64'(grav_est[i] * grav_est[i]);
      r.grav[i] = 16'(grav_est[i]);
      r.lin[i] = 17'(lin[i]);
    end
    // fall back to straight up when gravity is under a tenth of a g
    if (s_grav * 25 > 64'(gtmd_pkg::SMALL_G_LIM)) begin
      for (int i = 0; i < 3; i++) begin
        g = grav_est[i];
        q = longint'(int_sqrt((64'(g * g) << 28) / s_grav));
        r.up[i] = 16'(g < 0 ? -q : q);
      end
    end else begin
      default_up_count++;
      r.up[0] = 0; r.up[1] = 0; r.up[2] = gtmd_pkg::UP_ONE;
    end
    uz = r.up[2] < 0 ? 64'(-longint'(r.up[2])) : 64'(r.up[2]);
    if (uz > 16384) uz = 16384;
    idx = (uz * (ACOS_DEPTH - 1) + 8192) >> 14;
    if (idx > ACOS_DEPTH - 1) idx = ACOS_DEPTH - 1;
    r.tilt = acos_lut[idx];
    lmag = int_sqrt(s_lin);
    gmag = int_sqrt(s_rate << 14);
    motion = lmag + 64'(gyro_weight) * gmag;
    if (motion > 64'hFFFF_FFFF) motion = 64'hFFFF_FFFF;
    r.motion_level = motion[31:0];
    r.moving = motion > 64'(motion_threshold);
    if (r.moving) moving_count++;
    samples_seen++;
    expected_q.push_back(r);
  endfunction

  function void check_result(tilt_result_t got);
    tilt_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      $error("result transfer with nothing expected");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    for (int i = 0; i < 3; i++) begin
      if (got.grav[i] !== e.grav[i]) begin
        $error("grav[%0d] expected %0d got %0d", i, e.grav[i], got.grav[i]); errors++;
      end
      if (got.lin[i] !== e.lin[i]) begin
        $error("lin[%0d] expected %0d got %0d", i, e.lin[i], got.lin[i]); errors++;
      end
      if (got.up[i] !== e.up[i]) begin
        $error("up[%0d] expected %0d got %0d", i, e.up[i], got.up[i]); errors++;
      end
    end
    if (got.tilt !== e.tilt) begin
      $error("tilt expected %0d got %0d", e.tilt, got.tilt); errors++;
    end
    if (got.motion_level !== e.motion_level) begin
      $error("motion_level expected %0d got %0d", e.motion_level, got.motion_level);
      errors++;
    end
    if (got.moving !== e.moving) begin
      $error("moving expected %0b got %0b", e.moving, got.moving); errors++;
    end
  endfunction
endclass

module tb_gravity_tilt_motion_detector_top;
  import gtmd_pkg::*;

  localparam int LAT_SLACK   = 400;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i, rate_z_i;
  logic signed [15:0] grav_x_o, grav_y_o, grav_z_o, up_x_o, up_y_o, up_z_o;
  logic signed [16:0] lin_x_o, lin_y_o, lin_z_o;
  logic [12:0] tilt_o;
  logic [31:0] motion_level_o;
  logic moving_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  tilt_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_req, cycles;

  gravity_tilt_motion_detector_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: give up well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result monitor: check every accepted transfer against the oldest prediction
  always @(posedge clk_i) begin
    tilt_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.grav[0] = grav_x_o; got.grav[1] = grav_y_o; got.grav[2] = grav_z_o;
      got.lin[0]  = lin_x_o;  got.lin[1]  = lin_y_o;  got.lin[2]  = lin_z_o;
      got.up[0]   = up_x_o;   got.up[1]   = up_y_o;   got.up[2]   = up_z_o;
      got.tilt = tilt_o;
      got.motion_level = motion_level_o;
      got.moving = moving_o;
      sb.check_result(got);
    end
  end

  // entered and left at a falling edge; valid is left high for the next sample
  task automatic send_sample(imu_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    accel_x_i = s.accel[0]; accel_y_i = s.accel[1]; accel_z_i = s.accel[2];
    rate_x_i = s.rate[0]; rate_y_i = s.rate[1]; rate_z_i = s.rate[2];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // drain: every prediction matched, then let the datapath settle
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (LAT_SLACK) @(negedge clk_i);
  endtask

  function automatic imu_sample_t make_sample(int ax, int ay, int az,
                                              int rx, int ry, int rz);
    imu_sample_t s;
    s.accel[0] = 16'(ax); s.accel[1] = 16'(ay); s.accel[2] = 16'(az);
    s.rate[0] = 16'(rx); s.rate[1] = 16'(ry); s.rate[2] = 16'(rz);
    return s;
  endfunction

  // mostly a sensor at rest near 1 g in a random attitude, the rest raw noise
  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    int x, y, z;
    if ($urandom_range(99) < 75) begin
      x = int'($urandom_range(2800)) - 1400;
      y = int'($urandom_range(2800)) - 1400;
      z = int'(sb.int_sqrt(64'(4194304 - x * x - y * y)));
      if ($urandom_range(1)) z = -z;
      x += int'($urandom_range(400)) - 200;
      z += int'($urandom_range(400)) - 200;
      s = make_sample(x, y, z, int'($urandom_range(4000)) - 2000,
                      int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000);
      if ($urandom_range(9) == 0) s.accel[$urandom_range(2)] = 16'(int'($urandom_range(6000)) - 3000);
    end else begin
      s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return s;
  endfunction

  initial begin
    logic [31:0] setting [PHASES][5];
    sb = new();
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0; cycles = 0;
    in_valid_i = 1'b0; cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    accel_x_i = '0; accel_y_i = '0; accel_z_i = '0;
    rate_x_i = '0; rate_y_i = '0; rate_z_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: first load at zero (default up), rail values, attitudes, gate edges
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 2048, 0, 0, 0));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(0, 0, RST_GATE_LOW, 16, -16, 0));
    send_sample(make_sample(0, 0, RST_GATE_HIGH, 0, 0, 0));
    send_sample(make_sample(0, 0, 2048, 0, 0, 0));
    send_sample(make_sample(2048, 0, 0, 100, 0, 0));
    send_sample(make_sample(0, -2048, 0, 0, 100, 0));
    send_sample(make_sample(0, 0, -2048, 0, 0, 100));
    send_sample(make_sample(-32768, 32767, 0, 32767, -32768, 1));
    send_sample(make_sample(1500, 1500, 0, -1, -1, -1));
    drain();
    // write the filter, gate and gyro registers, plus unmapped indexes and masked high bits
    write_cfg(REG_MOTION_THRESHOLD + 3'd1, 32'hFFFF_FFFF);
    write_cfg(REG_MOTION_THRESHOLD + 3'd3, 32'h0);
    write_cfg(REG_FILTER_WEIGHT, 32'h0);
    write_cfg(REG_GATE_LOW, 32'h0);
    write_cfg(REG_GATE_HIGH, 32'hFFFF_0010);
    write_cfg(REG_GYRO_WEIGHT, 32'hFFFF_FF00);
    send_sample(make_sample(0, 0, 8, 0, 0, 0));
    send_sample(make_sample(1, 2, 3, 4, 5, 6));
    drain();

    setting[0] = '{19661, 1638, 2458, 10, 2048};
    setting[1] = '{0, 1638, 2458, 10, 0};
    setting[2] = '{65535, 0, 65535, 255, 32'hFFFF_FFFF};
    setting[3] = '{32768, 2458, 1638, 0, 5000};
    setting[4] = '{19661, 2000, 2000, 200, 100000};
    setting[5] = '{$urandom, $urandom, $urandom, $urandom, $urandom};
    setting[6] = '{1, 1000, 3000, 1, 1};
    setting[7] = '{65535, 1638, 2458, 255, 0};

    for (int p = 0; p < PHASES; p++) begin
      write_cfg(REG_FILTER_WEIGHT, setting[p][0]);
      write_cfg(REG_GATE_LOW, setting[p][1]);
      write_cfg(REG_GATE_HIGH, setting[p][2]);
      write_cfg(REG_GYRO_WEIGHT, setting[p][3]);
      write_cfg(REG_MOTION_THRESHOLD, setting[p][4]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // hold the output long enough that the input side has to stall
      if (p == 2) hold_req = 3000;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(random_sample());
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("checked %0d results from %0d samples over %0d register settings",
             sb.results_seen, sb.samples_seen, PHASES + 2);
    $display("filter updates %0d, default up %0d, moving %0d",
             sb.gated_updates, sb.default_up_count, sb.moving_count);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gtmd_pkg.sv
src/gravity_tilt_motion_detector_top.sv
bench/tb_gravity_tilt_motion_detector_top.sv
